// ===== rtl/core/tfb_pkg.sv =====
package tfb_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned HDR_LEN   = 16;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);

    // Input commands, carried on tuser
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // CRC-16/CCITT-FALSE
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Length codes and the payload lengths they select
    localparam logic [BYTE_W-1:0] LEN_CODE_128 = 8'h1F;
    localparam logic [BYTE_W-1:0] LEN_CODE_255 = 8'h2F;
    localparam logic [BYTE_W-1:0] LEN_128      = 8'd128;
    localparam logic [BYTE_W-1:0] LEN_255      = 8'd255;
    localparam logic [BYTE_W-1:0] LEN_DEFAULT  = 8'd84;

    // Result index of the two CRC bytes after the final payload byte
    localparam logic [HDR_IDX_W-1:0] IDX_CRC_HI = 4'd1;
    localparam logic [HDR_IDX_W-1:0] IDX_CRC_LO = 4'd2;
    localparam logic [HDR_IDX_W-1:0] IDX_HDR_END = 4'(HDR_LEN - 1);

    // What the item being expanded produces
    typedef enum logic [1:0] {
        KIND_HDR,
        KIND_DATA,
        KIND_LAST
    } t_kind;

    // Payload length selected by a length code
    function automatic logic [BYTE_W-1:0] len_decode(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] len;
        if (code == LEN_CODE_128) begin
            len = LEN_128;
        end else if (code == LEN_CODE_255) begin
            len = LEN_255;
        end else begin
            len = LEN_DEFAULT;
        end
        return len;
    endfunction

    // Header byte at a given position; the length high byte is always zero
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                                   input logic [BYTE_W-1:0]    len);
        logic [BYTE_W-1:0] b;
        case (idx) inside
            4'd0:        b = 8'hD2;
            4'd1:        b = 8'h8C;
            4'd2:        b = 8'h00;
            4'd3:        b = 8'h0A;
            [4'd4:4'd10]: b = 8'hFF;
            4'd11:       b = 8'h00;
            4'd12:       b = 8'h23;
            4'd13:       b = 8'hFF;
            4'd14:       b = 8'h00;
            default:     b = len;
        endcase
        return b;
    endfunction

    // Fold one byte into the CRC, MSB first
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0]  crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/telemetry_frame_builder_crc16_unit.sv =====
// Channel  Dir  Ports                 tdata (low bit up)            tuser / tlast
// -------  ---  --------------------  ----------------------------  ---------------------------
// s_axis   in   i_s_axis_t*, o_s_*    length_code, payload_byte     tuser: command
// m_axis   out  o_m_axis_t*, i_m_*    frame_byte                    tlast: last_of_run,
//                                                                   tuser: end_of_frame
//
// A new payload byte can be taken every cycle while the output does not stall.
// A start item yields 16 header bytes, a final payload byte itself plus two CRC bytes:
// the single result register drains one frame byte per cycle while not stalled and sets the pace.
// A payload byte with no open frame is taken and dropped.
// Reset (synchronous, active low) clears the CRC to FFFF and closes the frame.
// Output stalls back up through the result register into o_s_axis_tready.
module telemetry_frame_builder_crc16_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] length_code, [15:8] payload_byte
    input  logic        i_s_axis_tuser,   // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] frame_byte
    output logic        o_m_axis_tlast,   // last_of_run
    output logic        o_m_axis_tuser    // [0] end_of_frame
);

    localparam int unsigned BW = tfb_pkg::BYTE_W;
    localparam int unsigned IW = tfb_pkg::HDR_IDX_W;

    // Frame state
    logic [tfb_pkg::CRC_W-1:0] r_crc,    n_crc;
    logic [BW-1:0]             r_rem,    n_rem;
    logic                      r_active, n_active;

    // Item being expanded into results
    logic                      r_busy,   n_busy;
    tfb_pkg::t_kind            r_kind,   n_kind;
    logic [IW-1:0]             r_idx,    n_idx;
    logic [BW-1:0]             r_byte,   n_byte;
    logic [BW-1:0]             r_len,    n_len;

    // Result register
    logic                      r_ovalid, n_ovalid;
    logic [BW-1:0]             r_odata,  n_odata;
    logic                      r_olast,  n_olast;
    logic                      r_oeof,   n_oeof;

    logic                      w_s_acc;
    logic                      w_load;
    logic [BW-1:0]             w_gen_byte;
    logic                      w_gen_last;
    logic                      w_gen_eof;
    logic [BW-1:0]             w_in_len;
    logic [BW-1:0]             w_in_byte;
    logic [tfb_pkg::CRC_W-1:0] w_crc_fold;
    logic [BW-1:0]             w_rem_dec;

    assign w_in_len  = i_s_axis_tdata[BW-1:0];
    assign w_in_byte = i_s_axis_tdata[2*BW-1:BW];

    // Produce the current result of the held item
    always_comb begin
        w_gen_byte = r_byte;
        w_gen_last = 1'b1;
        w_gen_eof  = 1'b0;
        case (r_kind)
            tfb_pkg::KIND_HDR: begin
                w_gen_byte = tfb_pkg::hdr_byte(r_idx, r_len);
                w_gen_last = (r_idx == tfb_pkg::IDX_HDR_END);
            end
            tfb_pkg::KIND_DATA: begin
                w_gen_byte = r_byte;
                w_gen_last = 1'b1;
            end
            tfb_pkg::KIND_LAST: begin
                if (r_idx == tfb_pkg::IDX_CRC_HI) begin
                    w_gen_byte = r_crc[tfb_pkg::CRC_W-1:BW];
                    w_gen_last = 1'b0;
                end else if (r_idx == tfb_pkg::IDX_CRC_LO) begin
                    w_gen_byte = r_crc[BW-1:0];
                    w_gen_last = 1'b1;
                    w_gen_eof  = 1'b1;
                end else begin
                    w_gen_byte = r_byte;
                    w_gen_last = 1'b0;
                end
            end
            default: begin
                w_gen_byte = r_byte;
                w_gen_last = 1'b1;
            end
        endcase
    end

    // Handshakes: load the result register when it is empty or draining
    assign w_load          = r_busy && (!r_ovalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_busy || (w_load && w_gen_last);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    assign w_crc_fold = tfb_pkg::crc_fold(r_crc, w_in_byte);
    assign w_rem_dec  = r_rem - BW'(1);

    // Next state of frame, expander and result register
    always_comb begin
        n_crc    = r_crc;
        n_rem    = r_rem;
        n_active = r_active;
        n_busy   = r_busy;
        n_kind   = r_kind;
        n_idx    = r_idx;
        n_byte   = r_byte;
        n_len    = r_len;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_oeof   = r_oeof;

        // Drain the result register
        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        // Advance the expander
        if (w_load) begin
            n_ovalid = 1'b1;
            n_odata  = w_gen_byte;
            n_olast  = w_gen_last;
            n_oeof   = w_gen_eof;
            n_idx    = r_idx + IW'(1);
            if (w_gen_last) begin
                n_busy = 1'b0;
            end
        end

        // Take a new item
        if (w_s_acc) begin
            n_idx  = '0;
            n_byte = w_in_byte;
            if (i_s_axis_tuser == tfb_pkg::CMD_START) begin
                n_len    = tfb_pkg::len_decode(w_in_len);
                n_crc    = tfb_pkg::CRC_INIT;
                n_rem    = n_len;
                n_active = 1'b1;
                n_busy   = 1'b1;
                n_kind   = tfb_pkg::KIND_HDR;
            end else if (r_active) begin
                n_crc  = w_crc_fold;
                n_rem  = w_rem_dec;
                n_busy = 1'b1;
                if (w_rem_dec == '0) begin
                    n_active = 1'b0;
                    n_kind   = tfb_pkg::KIND_LAST;
                end else begin
                    n_kind   = tfb_pkg::KIND_DATA;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= tfb_pkg::CRC_INIT;
            r_rem    <= '0;
            r_active <= 1'b0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_kind   <= tfb_pkg::KIND_DATA;
            r_idx    <= '0;
        end else begin
            r_crc    <= n_crc;
            r_rem    <= n_rem;
            r_active <= n_active;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
            r_kind   <= n_kind;
            r_idx    <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_len   <= n_len;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_oeof  <= n_oeof;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_oeof;

`ifndef SYNTHESIS
    // An open frame always has payload bytes still expected
    a_active_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rem != '0))
        else $error("open frame with no payload bytes left");

    // End of frame is always the last result of its item
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("end of frame without tlast");

    // The final payload byte closes the frame
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (i_s_axis_tuser == tfb_pkg::CMD_PAYLOAD) && r_active
         && (r_rem == BW'(1))) |=> (!r_active && r_busy && (r_kind == tfb_pkg::KIND_LAST)))
        else $error("final payload byte did not close the frame");

    // A closing item never runs past the low CRC byte
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_kind == tfb_pkg::KIND_LAST)) |-> (r_idx <= tfb_pkg::IDX_CRC_LO))
        else $error("closing item index out of range");

    // A start restarts the CRC
    a_start_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (i_s_axis_tuser == tfb_pkg::CMD_START))
        |=> (r_crc == tfb_pkg::CRC_INIT && r_active))
        else $error("start did not reset the CRC");
`endif

endmodule
